@@ sv/mdu_pkg.sv @@
package mdu_pkg;

	// coefficient magnitudes and the shared divider work on 64-bit words
	localparam int MAG_BITS = 64;
	localparam int CNT_BITS = 6;
	localparam int ADDR_BITS = 4;

	// register byte addresses
	localparam logic [ADDR_BITS-1:0] ADDR_MODULUS = 4'h0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EUC_START,
		ST_EUC_DIV,
		ST_EUC_UPD,
		ST_INV_START,
		ST_INV_DIV,
		ST_INV_DONE,
		ST_NUM_START,
		ST_NUM_DIV,
		ST_NUM_DONE,
		ST_MUL,
		ST_FIN
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_EUC_START,
		OP_DIV_STEP,
		OP_EUC_UPD,
		OP_INV_START,
		OP_INV_DONE,
		OP_NUM_START,
		OP_NUM_DONE,
		OP_MUL_STEP,
		OP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic mod_zero;
		logic nr_zero;
	} status_t;

endpackage

@@ sv/mdu_datapath.sv @@
module mdu_datapath #(
	parameter int MOD_BITS = 63
) (
	input  logic                clk,
	input  mdu_pkg::cmd_t       cmd,
	output mdu_pkg::status_t    status,
	input  logic [MOD_BITS-1:0] modulus,
	input  logic [MOD_BITS-1:0] numerator,
	input  logic [MOD_BITS-1:0] denominator,
	output logic [MOD_BITS-1:0] quotient
);

	localparam int MB = mdu_pkg::MAG_BITS;

	// euclid remainders and signed-magnitude coefficients
	logic [MOD_BITS-1:0] r_q, nr_q, num_q;
	logic                t_neg_q, nt_neg_q;
	logic [MB-1:0]       t_mag_q, nt_mag_q;

	// shared restoring divider
	logic [MB-1:0]       dvd_q, prod_q;
	logic [MOD_BITS-1:0] rem_q, dsr_q;

	// modular multiplier
	logic [MOD_BITS-1:0] a_q, b_q, acc_q, res_q;

	logic [MOD_BITS:0]   shl;
	logic                ge;
	logic [MOD_BITS:0]   sub;
	logic [MOD_BITS-1:0] rem_n;
	logic [MB-1:0]       inv;
	logic                tmp_neg, sub_neg;
	logic [MB-1:0]       sub_mag;
	logic [MOD_BITS-1:0] dbl, acc_n;

	function automatic logic [MOD_BITS-1:0] add_mod(input logic [MOD_BITS-1:0] x,
			input logic [MOD_BITS-1:0] y, input logic [MOD_BITS-1:0] m);
		logic [MOD_BITS:0] s;
		logic [MOD_BITS:0] d;
		s = {1'b0, x} + {1'b0, y};
		d = s - {1'b0, m};
		add_mod = (s >= {1'b0, m}) ? d[MOD_BITS-1:0] : s[MOD_BITS-1:0];
	endfunction

	// one divider step
	always_comb begin
		shl = {rem_q, dvd_q[MB-1]};
		ge = shl >= {1'b0, dsr_q};
		sub = shl - {1'b0, dsr_q};
		rem_n = ge ? sub[MOD_BITS-1:0] : shl[MOD_BITS-1:0];
	end

	// t - q*nt in sign and magnitude, q*nt held in prod_q
	always_comb begin
		tmp_neg = nt_neg_q && (prod_q != '0);
		sub_neg = t_neg_q;
		sub_mag = t_mag_q;
		if (prod_q != '0) begin
			if (t_neg_q == !tmp_neg) begin
				sub_mag = t_mag_q + prod_q;
			end else if (t_mag_q >= prod_q) begin
				sub_mag = t_mag_q - prod_q;
			end else begin
				sub_neg = !tmp_neg;
				sub_mag = prod_q - t_mag_q;
			end
			if (sub_mag == '0) begin
				sub_neg = 1'b0;
			end
		end
	end

	// final coefficient corrected into the field
	assign inv = t_neg_q ? ({{(MB-MOD_BITS){1'b0}}, modulus} - t_mag_q) : t_mag_q;

	// one multiplier step, msb of b first
	always_comb begin
		dbl = add_mod(acc_q, acc_q, modulus);
		acc_n = b_q[MOD_BITS-1] ? add_mod(dbl, a_q, modulus) : dbl;
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			mdu_pkg::OP_LOAD: begin
				r_q <= modulus;
				nr_q <= denominator;
				num_q <= numerator;
				t_neg_q <= 1'b0;
				t_mag_q <= '0;
				nt_neg_q <= 1'b0;
				nt_mag_q <= MB'(1);
			end
			mdu_pkg::OP_EUC_START: begin
				dvd_q <= MB'(r_q);
				dsr_q <= nr_q;
				rem_q <= '0;
				prod_q <= '0;
			end
			mdu_pkg::OP_DIV_STEP: begin
				rem_q <= rem_n;
				dvd_q <= {dvd_q[MB-2:0], ge};
				prod_q <= {prod_q[MB-2:0], 1'b0} + (ge ? nt_mag_q : '0);
			end
			mdu_pkg::OP_EUC_UPD: begin
				t_neg_q <= nt_neg_q;
				t_mag_q <= nt_mag_q;
				nt_neg_q <= sub_neg;
				nt_mag_q <= sub_mag;
				r_q <= nr_q;
				nr_q <= rem_q;
			end
			mdu_pkg::OP_INV_START: begin
				dvd_q <= inv;
				dsr_q <= modulus;
				rem_q <= '0;
			end
			mdu_pkg::OP_INV_DONE: begin
				b_q <= rem_q;
			end
			mdu_pkg::OP_NUM_START: begin
				dvd_q <= MB'(num_q);
				dsr_q <= modulus;
				rem_q <= '0;
			end
			mdu_pkg::OP_NUM_DONE: begin
				a_q <= rem_q;
				acc_q <= '0;
			end
			mdu_pkg::OP_MUL_STEP: begin
				acc_q <= acc_n;
				b_q <= {b_q[MOD_BITS-2:0], 1'b0};
			end
			mdu_pkg::OP_OUT_LOAD: begin
				res_q <= (modulus == '0) ? '0 : acc_q;
			end
			default: begin
			end
		endcase
	end

	assign status.mod_zero = (modulus == '0);
	assign status.nr_zero = (nr_q == '0);
	assign quotient = res_q;

endmodule

@@ sv/mdu_ctrl.sv @@
module mdu_ctrl #(
	parameter int MOD_BITS = 63
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  mdu_pkg::status_t status,
	output mdu_pkg::cmd_t    cmd
);

	localparam logic [mdu_pkg::CNT_BITS-1:0] DIV_LAST = mdu_pkg::CNT_BITS'(mdu_pkg::MAG_BITS - 1);
	localparam logic [mdu_pkg::CNT_BITS-1:0] MUL_LAST = mdu_pkg::CNT_BITS'(MOD_BITS - 1);

	mdu_pkg::state_t state_q, state_n;
	logic [mdu_pkg::CNT_BITS-1:0] cnt_q;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			mdu_pkg::ST_IDLE:      if (in_valid) state_n = mdu_pkg::ST_CHECK;
			mdu_pkg::ST_CHECK: begin
				if (status.mod_zero) state_n = mdu_pkg::ST_FIN;
				else if (status.nr_zero) state_n = mdu_pkg::ST_INV_START;
				else state_n = mdu_pkg::ST_EUC_START;
			end
			mdu_pkg::ST_EUC_START: state_n = mdu_pkg::ST_EUC_DIV;
			mdu_pkg::ST_EUC_DIV:   if (cnt_q == DIV_LAST) state_n = mdu_pkg::ST_EUC_UPD;
			mdu_pkg::ST_EUC_UPD:   state_n = mdu_pkg::ST_CHECK;
			mdu_pkg::ST_INV_START: state_n = mdu_pkg::ST_INV_DIV;
			mdu_pkg::ST_INV_DIV:   if (cnt_q == DIV_LAST) state_n = mdu_pkg::ST_INV_DONE;
			mdu_pkg::ST_INV_DONE:  state_n = mdu_pkg::ST_NUM_START;
			mdu_pkg::ST_NUM_START: state_n = mdu_pkg::ST_NUM_DIV;
			mdu_pkg::ST_NUM_DIV:   if (cnt_q == DIV_LAST) state_n = mdu_pkg::ST_NUM_DONE;
			mdu_pkg::ST_NUM_DONE:  state_n = mdu_pkg::ST_MUL;
			mdu_pkg::ST_MUL:       if (cnt_q == MUL_LAST) state_n = mdu_pkg::ST_FIN;
			mdu_pkg::ST_FIN:       if (out_free) state_n = mdu_pkg::ST_IDLE;
			default:               state_n = mdu_pkg::ST_IDLE;
		endcase
	end

	// datapath command
	always_comb begin
		cmd.op = mdu_pkg::OP_NONE;
		unique case (state_q)
			mdu_pkg::ST_IDLE:      if (in_valid) cmd.op = mdu_pkg::OP_LOAD;
			mdu_pkg::ST_EUC_START: cmd.op = mdu_pkg::OP_EUC_START;
			mdu_pkg::ST_EUC_DIV, mdu_pkg::ST_INV_DIV, mdu_pkg::ST_NUM_DIV:
				cmd.op = mdu_pkg::OP_DIV_STEP;
			mdu_pkg::ST_EUC_UPD:   cmd.op = mdu_pkg::OP_EUC_UPD;
			mdu_pkg::ST_INV_START: cmd.op = mdu_pkg::OP_INV_START;
			mdu_pkg::ST_INV_DONE:  cmd.op = mdu_pkg::OP_INV_DONE;
			mdu_pkg::ST_NUM_START: cmd.op = mdu_pkg::OP_NUM_START;
			mdu_pkg::ST_NUM_DONE:  cmd.op = mdu_pkg::OP_NUM_DONE;
			mdu_pkg::ST_MUL:       cmd.op = mdu_pkg::OP_MUL_STEP;
			mdu_pkg::ST_FIN:       if (out_free) cmd.op = mdu_pkg::OP_OUT_LOAD;
			default:               cmd.op = mdu_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mdu_pkg::ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			// step counter for divider and multiplier loops
			if (state_q == mdu_pkg::ST_EUC_DIV || state_q == mdu_pkg::ST_INV_DIV ||
					state_q == mdu_pkg::ST_NUM_DIV || state_q == mdu_pkg::ST_MUL) begin
				cnt_q <= (state_n == state_q) ? cnt_q + 1'b1 : '0;
			end else begin
				cnt_q <= '0;
			end
			// output register handshake
			if (state_q == mdu_pkg::ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall = (state_q != mdu_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

@@ sv/modular_division_unit.sv @@
// Modular division: quotient = numerator * denominator^-1 mod modulus, the inverse
// found by the extended Euclidean algorithm and the product reduced by a
// shift-and-add modular multiplier. One transaction is worked at a time; a
// finished result waits in an output register while the next transaction is
// taken. Each Euclid step, of which there are up to roughly 1.44*MOD_BITS for
// a given denominator, and each of the two reductions makes one full 64-step
// pass of the single shared restoring divider. A zero denominator skips the
// Euclid loop and gives 0; a zero modulus gives 0. The modulus register sits at
// byte address 0 and resets to 2; write it only while no transaction is open.
module modular_division_unit #(
	parameter int MOD_BITS = 63
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mdu_pkg::ADDR_BITS-1:0] paddr,
	input  logic [63:0]                   pwdata,
	output logic [63:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [MOD_BITS-1:0]           numerator,
	input  logic [MOD_BITS-1:0]           denominator,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [MOD_BITS-1:0]           quotient
);

	logic [MOD_BITS-1:0] modulus_q;
	mdu_pkg::cmd_t       cmd;
	mdu_pkg::status_t    status;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_BITS'(2);
		end else if (psel && penable && pwrite && paddr == mdu_pkg::ADDR_MODULUS) begin
			modulus_q <= pwdata[MOD_BITS-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == mdu_pkg::ADDR_MODULUS) ? 64'(modulus_q) : '0;

	mdu_ctrl #(.MOD_BITS(MOD_BITS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	mdu_datapath #(.MOD_BITS(MOD_BITS)) u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.status      (status),
		.modulus     (modulus_q),
		.numerator   (numerator),
		.denominator (denominator),
		.quotient    (quotient)
	);

endmodule

@@ sv/mdu_checker.sv @@
module mdu_checker #(
	parameter int MOD_BITS = 63
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [MOD_BITS-1:0] quotient
);

	// a taken transaction keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after transaction");

	// a new result only appears once a transaction has been worked on
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without work");

	// stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(quotient))
		else $error("stalled result changed");

endmodule

bind modular_division_unit mdu_checker #(.MOD_BITS(MOD_BITS)) u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.quotient  (quotient)
);

@@ tb/sv/modular_division_unit_tb.sv @@
`timescale 1ns / 1ps

module modular_division_unit_tb;

	localparam int W = 63;
	localparam int STALL_LIMIT = 60000;
	localparam logic [W-1:0] MAX_VAL = {W{1'b1}};

	typedef struct {
		logic [W-1:0] num;
		logic [W-1:0] den;
	} div_req_t;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [mdu_pkg::ADDR_BITS-1:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [W-1:0] numerator = '0, denominator = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [W-1:0] quotient;

	div_req_t pending_reqs[$];
	logic [W-1:0] expected_quotients[$];
	logic [W-1:0] cur_modulus = 2;
	idle_mode_t idle_mode = IDLE_NONE;
	int mismatches = 0;
	int n_sent = 0, n_checked = 0, n_phases = 0;
	int quiet_cycles = 0;

	modular_division_unit #(.MOD_BITS(W)) dut (.*);

	always #6 clk = ~clk;

	function automatic logic [63:0] add_mod64(logic [63:0] x, logic [63:0] y,
			logic [63:0] m);
		if (x >= m - y)
			return x - (m - y);
		return x + y;
	endfunction

	// extended euclid inverse with sign-magnitude coefficients, then modular product
	function automatic logic [W-1:0] predict_quotient(logic [W-1:0] n, logic [W-1:0] d,
			logic [W-1:0] mod);
		logic [63:0] m, r, nr, q, tr, t_mag, nt_mag, p_mag, s_mag, inv, a, b, acc;
		logic t_neg, nt_neg, p_neg, s_neg, bneg;
		m = {1'b0, mod};
		if (m == 0)
			return '0;
		r = m; nr = {1'b0, d};
		t_mag = 0; t_neg = 0; nt_mag = 1; nt_neg = 0;
		while (nr != 0) begin
			q = r / nr;
			p_mag = q * nt_mag;
			p_neg = nt_neg && (p_mag != 0);
			bneg = !p_neg;
			if (p_mag == 0) begin
				s_mag = t_mag; s_neg = t_neg;
			end else if (t_neg == bneg) begin
				s_mag = t_mag + p_mag; s_neg = t_neg;
			end else if (t_mag >= p_mag) begin
				s_mag = t_mag - p_mag; s_neg = t_neg;
			end else begin
				s_mag = p_mag - t_mag; s_neg = bneg;
			end
			if (s_mag == 0)
				s_neg = 0;
			t_mag = nt_mag; t_neg = nt_neg;
			nt_mag = s_mag; nt_neg = s_neg;
			tr = r - q * nr;
			r = nr;
			nr = tr;
		end
		inv = t_neg ? m - t_mag : t_mag;
		a = {1'b0, n} % m;
		b = inv % m;
		acc = 0;
		for (int i = 63; i >= 0; i--) begin
			acc = add_mod64(acc, acc, m);
			if (b[i])
				acc = add_mod64(acc, a, m);
		end
		return acc[W-1:0];
	endfunction

	function automatic logic [W-1:0] rand_word();
		return {$urandom, $urandom} & MAX_VAL;
	endfunction

	function automatic bit idle_roll(bit sender);
		case (idle_mode)
			IDLE_SEND: return sender && $urandom_range(99) < 73;
			IDLE_RECV: return !sender && $urandom_range(99) < 73;
			IDLE_BOTH: return $urandom_range(99) < 33;
			default: return 0;
		endcase
	endfunction

	// input driver: predicts on each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			automatic bit busy = in_valid;
			if (in_valid && !in_stall) begin
				expected_quotients.push_back(predict_quotient(numerator, denominator,
					cur_modulus));
				n_sent++;
				busy = 0;
			end
			if (!busy) begin
				if (pending_reqs.size() != 0 && !idle_roll(1)) begin
					numerator <= pending_reqs[0].num;
					denominator <= pending_reqs[0].den;
					pending_reqs.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor, stall generation and watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= idle_roll(0);
			if (out_valid && !out_stall) begin
				if (expected_quotients.size() == 0) begin
					$error("quotient: none expected, actual %0d", quotient);
					mismatches++;
				end else begin
					if (quotient !== expected_quotients[0]) begin
						$error("quotient: expected %0d actual %0d",
							expected_quotients[0], quotient);
						mismatches++;
					end
					expected_quotients.pop_front();
				end
				n_checked++;
			end
			if ((out_valid && !out_stall) || (in_valid && !in_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic write_modulus(logic [W-1:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= mdu_pkg::ADDR_MODULUS; pwdata <= {1'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		cur_modulus = value;
	endtask

	task automatic push_req(logic [W-1:0] n, logic [W-1:0] d);
		div_req_t req;
		req.num = n;
		req.den = d;
		pending_reqs.push_back(req);
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || in_valid || expected_quotients.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		n_phases++;
	endtask

	// random phase: mostly reduced operands, some raw 63-bit words, zero or oversized denominators
	task automatic random_phase(logic [W-1:0] m, idle_mode_t mode, int count);
		logic [W-1:0] n, d;
		write_modulus(m);
		idle_mode = mode;
		for (int i = 0; i < count; i++) begin
			n = rand_word();
			d = rand_word();
			case ($urandom_range(9))
				0: ;
				1: d = 0;
				2: d = d % m + m * $urandom_range(1, 2);
				default: begin
					n = n % m;
					d = d % m;
				end
			endcase
			push_req(n, d);
		end
		drain();
	endtask

	localparam logic [W-1:0] P_BIG = 63'd9223372036854775783;
	localparam logic [W-1:0] P_M61 = 63'd2305843009213693951;

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset modulus, then extremes, zero and oversized operands
		push_req(0, 0); push_req(1, 1); push_req(MAX_VAL, MAX_VAL); push_req(1, 3);
		drain();
		write_modulus(P_BIG);
		push_req(0, 5); push_req(P_BIG - 1, 0); push_req(P_BIG - 1, P_BIG - 1);
		push_req(1, 1); push_req(MAX_VAL, 2); push_req(12345, P_BIG);
		push_req(7, P_BIG + 3); push_req(MAX_VAL, MAX_VAL); push_req(1, 2);
		drain();
		// composite modulus: denominators sharing a factor
		write_modulus(MAX_VAL);
		push_req(5, 7); push_req(9, 73); push_req(MAX_VAL, 49); push_req(3, 0);
		drain();
		write_modulus(63'd1000000);
		push_req(3, 10); push_req(999999, 4096); push_req(17, 999999);
		push_req(1, 1000002);
		drain();

		random_phase(63'd65521, IDLE_NONE, 350);
		random_phase(P_M61, IDLE_SEND, 250);
		random_phase(63'd1000003, IDLE_RECV, 350);
		random_phase(P_BIG, IDLE_BOTH, 250);
		random_phase(63'd3, IDLE_NONE, 150);
		random_phase(MAX_VAL, IDLE_BOTH, 150);
		random_phase(63'd1000000, IDLE_SEND, 150);
		random_phase(63'd2, IDLE_RECV, 150);

		if (expected_quotients.size() != 0) begin
			$error("quotient: %0d results never arrived", expected_quotients.size());
			mismatches++;
		end
		$display("ran %0d divisions over %0d phases, %0d results checked", n_sent,
			n_phases, n_checked);
		$display("moduli from 2 to 2^63-1, prime and composite, with idle and stall mixes");
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
